// ===== rtl/core/assignment_list_lexer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the assignment list lexer
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSIGNMENT_LIST_LEXER_UNIT_MACROS_SVH
`define ASSIGNMENT_LIST_LEXER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ALX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/alx_pkg.sv =====
// ----------------------------------------------------------------------------
// alx_pkg
// Widths, codes, characters and record types of the assignment list lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alx_pkg;

    localparam int OFFSET_BITS = 16;  // text offset range, 8..32
    localparam int OUT_W       = 16;  // offset and length fields on the port
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 3;
    localparam int MODE_W      = 3;
    localparam int PHASE_W     = 2;
    localparam int TOK_W       = 2;

    // lexer modes
    localparam logic [MODE_W-1:0] M_IDLE       = 3'd0;
    localparam logic [MODE_W-1:0] M_SLASH      = 3'd1;
    localparam logic [MODE_W-1:0] M_BLOCK      = 3'd2;
    localparam logic [MODE_W-1:0] M_BLOCK_STAR = 3'd3;
    localparam logic [MODE_W-1:0] M_LINE       = 3'd4;
    localparam logic [MODE_W-1:0] M_TEXT       = 3'd5;

    // grammar phases
    localparam logic [PHASE_W-1:0] P_NAME  = 2'd0;
    localparam logic [PHASE_W-1:0] P_EQ    = 2'd1;
    localparam logic [PHASE_W-1:0] P_VALUE = 2'd2;

    // token kinds
    localparam logic [TOK_W-1:0] TK_WORD   = 2'd0;
    localparam logic [TOK_W-1:0] TK_ASSIGN = 2'd1;
    localparam logic [TOK_W-1:0] TK_EOT    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [CODE_W-1:0] ERR_UNCLOSED    = 3'd1;
    localparam logic [CODE_W-1:0] ERR_MISSING_EQ  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_MISSING_VAL = 3'd3;
    localparam logic [CODE_W-1:0] ERR_UNEXPECTED  = 3'd4;
    localparam logic [CODE_W-1:0] ERR_TOO_LONG    = 3'd5;

    // characters
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [FIFO_AW-1:0] t_fptr;
    typedef logic [FIFO_AW:0]   t_fcnt;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [OUT_W-1:0]  name_off;
        logic [OUT_W-1:0]  name_len;
        logic [OUT_W-1:0]  val_off;
        logic [OUT_W-1:0]  val_len;
        logic              run_end;
    } t_result;

    // grammar state plus the results a byte has produced so far
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               failed;
        logic [OUT_W-1:0]   name_off;
        logic [OUT_W-1:0]   name_len;
        logic [1:0]         cnt;
        t_result            res0;
        t_result            res1;
    } t_ctx;

endpackage

// ===== rtl/core/alx_text_if.sv =====
// ----------------------------------------------------------------------------
// alx_text_if
// Input channel: one text byte per item, with a last-byte flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface alx_text_if import alx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/alx_result_if.sv =====
// ----------------------------------------------------------------------------
// alx_result_if
// Output channel: one lexer result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface alx_result_if import alx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [CODE_W-1:0] error_code;
    logic [OUT_W-1:0]  name_offset;
    logic [OUT_W-1:0]  name_length;
    logic [OUT_W-1:0]  value_offset;
    logic [OUT_W-1:0]  value_length;
    logic              run_end;

    modport source (
        output valid, output result_kind, output error_code, output name_offset,
        output name_length, output value_offset, output value_length,
        output run_end, input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input name_offset,
        input name_length, input value_offset, input value_length,
        input run_end, output ready
    );
endinterface

// ===== rtl/core/assignment_list_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// assignment_list_lexer_unit
// Byte-serial lexer/parser for "name = value" lists. It takes one text byte
// per cycle when not stalled, skips whitespace and block, slash-slash and hash
// comments, and reports each pair with name and value offset/length (trailing
// spaces trimmed), a done item at the last byte, or an error item (unclosed
// comment, missing '=', missing value, unexpected '=', text too long); after
// an error the rest of the text is swallowed until its last byte. Rate: one
// byte per cycle while the input is not stalled. An accepted byte sits in an
// input register, is lexed from there and its results land in a 4-deep
// result queue, whose head drives the output. The output drains one item per
// cycle while the receiver is ready; a byte that gives two items (pair plus
// done on the last byte, or pair plus error when a value ends at an '=')
// takes two queue slots. The input stalls only while a byte waits in the
// input register and the queue has fewer than two free slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assignment_list_lexer_unit_macros.svh"

module assignment_list_lexer_unit import alx_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alx_text_if.sink     i_text,
    alx_result_if.source o_result
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic t_result mk_res(input logic [KIND_W-1:0] kind,
                                       input logic [CODE_W-1:0] code,
                                       input logic [OUT_W-1:0]  no,
                                       input logic [OUT_W-1:0]  nl,
                                       input logic [OUT_W-1:0]  vo,
                                       input logic [OUT_W-1:0]  vl);
        t_result r;
        r.kind     = kind;
        r.code     = code;
        r.name_off = no;
        r.name_len = nl;
        r.val_off  = vo;
        r.val_len  = vl;
        r.run_end  = 1'b0;
        return r;
    endfunction

    // append a result; at most two per byte
    function automatic t_ctx emit(input t_ctx c, input t_result r);
        t_ctx o;
        o = c;
        if (c.cnt == 2'd0) begin
            o.res0 = r;
            o.cnt  = 2'd1;
        end else if (c.cnt == 2'd1) begin
            o.res1 = r;
            o.cnt  = 2'd2;
        end
        return o;
    endfunction

    function automatic t_ctx fail(input t_ctx c, input logic [CODE_W-1:0] code);
        t_ctx o;
        o        = c;
        o.failed = 1'b1;
        return emit(o, mk_res(KIND_ERROR, code, '0, '0, '0, '0));
    endfunction

    // grammar: name, '=', value
    function automatic t_ctx tok(input t_ctx c, input logic [TOK_W-1:0] kind,
                                 input logic [OUT_W-1:0] off,
                                 input logic [OUT_W-1:0] len);
        t_ctx o;
        o = c;
        case (kind)
            TK_WORD: begin
                case (c.phase)
                    P_NAME: begin
                        o.name_off = off;
                        o.name_len = len;
                        o.phase    = P_EQ;
                    end
                    P_EQ: o = fail(c, ERR_MISSING_EQ);
                    default: begin
                        o = emit(c, mk_res(KIND_PAIR, ERR_NONE, c.name_off, c.name_len,
                                           off, len));
                        o.phase = P_NAME;
                    end
                endcase
            end
            TK_ASSIGN: begin
                case (c.phase)
                    P_NAME:  o = fail(c, ERR_UNEXPECTED);
                    P_EQ:    o.phase = P_VALUE;
                    default: o = fail(c, ERR_MISSING_VAL);
                endcase
            end
            default: begin
                case (c.phase)
                    P_NAME:  o = emit(c, mk_res(KIND_DONE, ERR_NONE, '0, '0, '0, '0));
                    P_EQ:    o = fail(c, ERR_MISSING_EQ);
                    default: o = fail(c, ERR_MISSING_VAL);
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic logic [OUT_W-1:0] span_len(input logic [OFFSET_BITS-1:0] last,
                                                  input logic [OFFSET_BITS-1:0] first);
        logic [OFFSET_BITS:0] d;
        d = {1'b0, last} + {{OFFSET_BITS{1'b0}}, 1'b1} - {1'b0, first};
        return OUT_W'(d);
    endfunction

    localparam t_fcnt ROOM_LIMIT = t_fcnt'(FIFO_DEPTH - 2);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_fin;

    // lexer / grammar state
    logic [MODE_W-1:0]      r_mode;
    logic [PHASE_W-1:0]     r_phase;
    logic [OFFSET_BITS:0]   r_pos;      // extra bit flags an overlong text
    logic [OFFSET_BITS-1:0] r_ts;       // token start
    logic [OFFSET_BITS-1:0] r_ln;       // last non-space byte of token
    logic [OUT_W-1:0]       r_sno;      // saved name offset
    logic [OUT_W-1:0]       r_snl;      // saved name length
    logic                   r_failed;

    // result queue
    t_result r_fifo [FIFO_DEPTH];
    t_fptr   r_wr;
    t_fptr   r_rd;
    t_fcnt   r_count;

    logic room;
    logic step_en;
    logic in_acc;
    logic out_pop;
    t_fptr wr_alt;

    logic [MODE_W-1:0]      n_mode;
    logic [PHASE_W-1:0]     n_phase;
    logic [OFFSET_BITS:0]   n_pos;
    logic [OFFSET_BITS-1:0] n_ts;
    logic [OFFSET_BITS-1:0] n_ln;
    logic [OUT_W-1:0]       n_sno;
    logic [OUT_W-1:0]       n_snl;
    logic                   n_failed;
    logic [1:0]             n_push;
    t_result                n_res0;
    t_result                n_res1;
    t_fcnt                  n_count;

    assign room    = (r_count <= ROOM_LIMIT);
    assign step_en = r_in_valid && room;
    assign i_text.ready = !r_in_valid || room;
    assign in_acc  = i_text.valid && i_text.ready;
    assign out_pop = o_result.valid && o_result.ready;
    assign wr_alt  = r_wr + t_fptr'(1);

    // ------------------------------------------------------------------
    // Per-byte lexing: the whole step for one byte, up to two results
    // ------------------------------------------------------------------
    always_comb begin
        t_ctx                   c;
        logic [MODE_W-1:0]      mode;
        logic [OFFSET_BITS-1:0] ts;
        logic [OFFSET_BITS-1:0] ln;
        logic [OFFSET_BITS-1:0] idx;
        logic [OFFSET_BITS:0]   pos;
        logic                   was_failed;
        logic                   do_text;
        logic [BYTE_W-1:0]      ch;

        c          = '0;
        c.phase    = r_phase;
        c.failed   = r_failed;
        c.name_off = r_sno;
        c.name_len = r_snl;
        mode       = r_mode;
        ts         = r_ts;
        ln         = r_ln;
        pos        = r_pos;
        idx        = r_pos[OFFSET_BITS-1:0];
        was_failed = r_failed;
        do_text    = 1'b0;
        ch         = r_in_byte;

        if (!c.failed) begin
            if (pos[OFFSET_BITS]) begin
                c = fail(c, ERR_TOO_LONG);
            end else begin
                case (mode)
                    M_SLASH: begin
                        if (ch == CH_STAR) begin
                            mode = M_BLOCK;
                        end else if (ch == CH_SLASH) begin
                            mode = M_LINE;
                        end else begin
                            // lone slash opens a text token
                            mode    = M_TEXT;
                            ln      = ts;
                            do_text = 1'b1;
                        end
                    end
                    M_BLOCK: begin
                        if (ch == CH_STAR) mode = M_BLOCK_STAR;
                    end
                    M_BLOCK_STAR: begin
                        if (ch == CH_SLASH) begin
                            mode = M_IDLE;
                        end else if (ch != CH_STAR) begin
                            mode = M_BLOCK;
                        end
                    end
                    M_LINE: begin
                        if (ch == CH_NL) mode = M_IDLE;
                    end
                    M_TEXT: do_text = 1'b1;
                    default: begin
                        if (ch == CH_SLASH) begin
                            mode = M_SLASH;
                            ts   = idx;
                        end else if (ch == CH_HASH) begin
                            mode = M_LINE;
                        end else if (ch == CH_EQ) begin
                            c = tok(c, TK_ASSIGN, '0, '0);
                        end else if (!is_space(ch)) begin
                            mode = M_TEXT;
                            ts   = idx;
                            ln   = idx;
                        end
                    end
                endcase

                if (do_text) begin
                    if (ch == CH_NL || ch == CH_EQ) begin
                        mode = M_IDLE;
                        c = tok(c, TK_WORD, OUT_W'(ts), span_len(ln, ts));
                        // terminating '=' is then seen as a token of its own
                        if (!c.failed && ch == CH_EQ) begin
                            c = tok(c, TK_ASSIGN, '0, '0);
                        end
                    end else if (ch != CH_SP) begin
                        ln = idx;
                    end
                end
                pos = pos + {{OFFSET_BITS{1'b0}}, 1'b1};
            end
        end

        // end of text: flush the open token, then done
        if (r_in_fin) begin
            if (!c.failed) begin
                case (mode)
                    M_SLASH:      c = tok(c, TK_WORD, OUT_W'(ts), OUT_W'(1));
                    M_TEXT:       c = tok(c, TK_WORD, OUT_W'(ts), span_len(ln, ts));
                    M_BLOCK:      c = fail(c, ERR_UNCLOSED);
                    M_BLOCK_STAR: c = fail(c, ERR_UNCLOSED);
                    default:      c = c;
                endcase
                if (!c.failed) begin
                    c = tok(c, TK_EOT, '0, '0);
                end
            end else if (was_failed) begin
                c = emit(c, mk_res(KIND_DONE, ERR_NONE, '0, '0, '0, '0));
            end
        end

        if (c.cnt == 2'd1) c.res0.run_end = 1'b1;
        if (c.cnt == 2'd2) c.res1.run_end = 1'b1;

        if (r_in_fin) begin
            n_mode   = M_IDLE;
            n_phase  = P_NAME;
            n_pos    = '0;
            n_ts     = '0;
            n_ln     = '0;
            n_sno    = '0;
            n_snl    = '0;
            n_failed = 1'b0;
        end else begin
            n_mode   = mode;
            n_phase  = c.phase;
            n_pos    = pos;
            n_ts     = ts;
            n_ln     = ln;
            n_sno    = c.name_off;
            n_snl    = c.name_len;
            n_failed = c.failed;
        end
        n_push = step_en ? c.cnt : 2'd0;
        n_res0 = c.res0;
        n_res1 = c.res1;
    end

    assign n_count = r_count + t_fcnt'(n_push) - t_fcnt'(out_pop);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_phase    <= P_NAME;
            r_pos      <= '0;
            r_ts       <= '0;
            r_ln       <= '0;
            r_sno      <= '0;
            r_snl      <= '0;
            r_failed   <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (step_en) begin
                r_in_valid <= 1'b0;
            end
            if (step_en) begin
                r_mode   <= n_mode;
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_ts     <= n_ts;
                r_ln     <= n_ln;
                r_sno    <= n_sno;
                r_snl    <= n_snl;
                r_failed <= n_failed;
            end
            r_wr    <= r_wr + t_fptr'(n_push);
            r_rd    <= r_rd + t_fptr'(out_pop);
            r_count <= n_count;
        end
    end

    // byte payload and queue entries carry no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_text.text_byte;
            r_in_fin  <= i_text.final_byte;
        end
        if (n_push != 2'd0) begin
            r_fifo[r_wr] <= n_res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[wr_alt] <= n_res1;
        end
    end

    // ------------------------------------------------------------------
    // Output: head of the result queue
    // ------------------------------------------------------------------
    assign o_result.valid        = (r_count != '0);
    assign o_result.result_kind  = r_fifo[r_rd].kind;
    assign o_result.error_code   = r_fifo[r_rd].code;
    assign o_result.name_offset  = r_fifo[r_rd].name_off;
    assign o_result.name_length  = r_fifo[r_rd].name_len;
    assign o_result.value_offset = r_fifo[r_rd].val_off;
    assign o_result.value_length = r_fifo[r_rd].val_len;
    assign o_result.run_end      = r_fifo[r_rd].run_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ALX_ASSERT_IMPLIES(a_final_gives_result, i_clk, i_rst_n, step_en && r_in_fin, n_push != 2'd0, "last byte produced no result")
    `ALX_ASSERT_IMPLIES(a_failed_absorbs, i_clk, i_rst_n, step_en && r_failed && !r_in_fin, n_push == 2'd0, "byte after error produced a result")
    `ALX_ASSERT_NEXT(a_final_resets, i_clk, i_rst_n, step_en && r_in_fin, r_pos == '0 && !r_failed && r_mode == M_IDLE && r_phase == P_NAME, "state not cleared after last byte")

endmodule
